// ===== rtl/note_driven_light_controller_macros.svh =====
// Assertion macros for the note-driven light controller.
// Needs no other file; the RTL that asserts includes this header.
`ifndef NOTE_DRIVEN_LIGHT_CONTROLLER_MACROS_SVH
`define NOTE_DRIVEN_LIGHT_CONTROLLER_MACROS_SVH

`ifndef SYNTHESIS

// Whenever cond holds at an edge, prop holds at the same edge.
`define NLC_ASSERT_SAME(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("nlc assertion failed");

// Whenever cond holds at an edge, prop holds at the next edge.
`define NLC_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
      else $error("nlc assertion failed");

`else

`define NLC_ASSERT_SAME(label, clk, rst, cond, prop)
`define NLC_ASSERT_NEXT(label, clk, rst, cond, prop)

`endif

`endif

// ===== rtl/nlc_pkg.sv =====
// Shared types, constants and helpers of the note-driven light controller.
// Has no dependencies; the top level imports it.
package nlc_pkg;

   localparam int unsigned MAX_RATE_EXP_DEFAULT = 9;
   localparam int unsigned RATE_EXP_RESET       = 6;
   localparam int unsigned TICK_W               = 10;
   localparam int unsigned CSR_INDEX_W          = 2;
   localparam int unsigned CSR_DATA_W           = 8;

   // Request types.
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_NOTE_ON  = 2'd1;
   localparam logic [1:0] REQ_NOTE_OFF = 2'd2;

   // Register indexes.
   localparam logic [CSR_INDEX_W-1:0] CSR_RELEASE_LEVEL = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_GAIN          = 2'd1;

   localparam logic [7:0] RELEASE_LEVEL_RESET = 8'd255;
   localparam logic [7:0] GAIN_RESET          = 8'd1;
   localparam logic [7:0] STEADY_LEVEL        = 8'd55;
   localparam logic [7:0] STROBE_HIGH         = 8'd255;

   // Keys.
   localparam logic [6:0] KEY_RATE_UP   = 7'd49;
   localparam logic [6:0] KEY_RATE_DOWN = 7'd51;
   localparam logic [6:0] LEVEL_KEY  [3] = '{7'd48, 7'd50, 7'd52};
   localparam logic [6:0] STEADY_KEY [3] = '{7'd53, 7'd55, 7'd57};
   localparam logic [6:0] STROBE_KEY [3] = '{7'd59, 7'd60, 7'd62};
   localparam logic [6:0] REDRAW_KEY [3] = '{7'd64, 7'd65, 7'd67};

   // Frame bytes and escaping.
   localparam logic [7:0] FRAME_START = 8'h42;
   localparam logic [7:0] BYTE_HASH   = 8'h23;
   localparam logic [7:0] BYTE_START  = 8'h42;
   localparam logic [7:0] BYTE_ESC    = 8'h65;
   localparam logic [7:0] BYTE_SIXTY6 = 8'h66;
   localparam logic [2:0] ESC_NONE    = 3'd0;
   localparam logic [2:0] ESC_HASH    = 3'd1;
   localparam logic [2:0] ESC_START   = 3'd2;
   localparam logic [2:0] ESC_ESC     = 3'd3;
   localparam logic [2:0] ESC_SIXTY6  = 3'd4;

   // Frame positions: start byte, two zero bytes, then red, green, blue.
   localparam logic [2:0] POS_START = 3'd0;
   localparam logic [2:0] POS_ZERO0 = 3'd1;
   localparam logic [2:0] POS_ZERO1 = 3'd2;
   localparam logic [2:0] POS_RED   = 3'd3;
   localparam logic [2:0] POS_GREEN = 3'd4;
   localparam logic [2:0] POS_BLUE  = 3'd5;

   typedef struct packed {
      logic [1:0] req_type;
      logic [6:0] note;
      logic [6:0] velocity;
   } req_payload_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last;
   } rsp_payload_type;

   // Returns the escape code that follows the escape byte, or none.
   function automatic logic [2:0] esc_code(input logic [7:0] b);
      logic [2:0] code;
      case (b)
         BYTE_HASH:   code = ESC_HASH;
         BYTE_START:  code = ESC_START;
         BYTE_ESC:    code = ESC_ESC;
         BYTE_SIXTY6: code = ESC_SIXTY6;
         default:     code = ESC_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/note_driven_light_controller.sv =====
// Note-driven light controller: a rendering tick emits one escaped frame of 6 to 9
// result transfers, one per cycle while rsp is not stalled, which reach rsp once the
// frame buffer and then the output register are loaded. Note events are accepted
// while a frame drains. A tick is held off while a frame drains, so with the single
// frame buffer and byte-wide output a new frame never starts before the last has left.
// Reset is synchronous and active high; all but the payload registers return to reset values.
`include "note_driven_light_controller_macros.svh"

module note_driven_light_controller #(
   parameter int unsigned MAX_RATE_EXP = nlc_pkg::MAX_RATE_EXP_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  nlc_pkg::req_payload_type            req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output nlc_pkg::rsp_payload_type            rsp_data,
   input  logic                                csr_we,
   input  logic [nlc_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [nlc_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   import nlc_pkg::*;

   // The rate exponent must hold both its reset value and its ceiling.
   localparam int unsigned RATE_TOP =
      (MAX_RATE_EXP > RATE_EXP_RESET) ? MAX_RATE_EXP : RATE_EXP_RESET;
   localparam int unsigned RATE_W = $clog2(RATE_TOP + 1);

   // Configuration registers.
   logic [7:0] release_level_ff;
   logic [7:0] gain_ff;

   // Lighting state. Channel order is red, green, blue.
   logic [7:0]        level_ff [3];
   logic [7:0]        level_in [3];
   logic [2:0]        steady_ff, steady_in;
   logic [2:0]        strobe_ff, strobe_in;
   logic [RATE_W-1:0] rate_ff, rate_in;
   logic [TICK_W-1:0] tick_ff, tick_in;
   logic              redraw_ff, redraw_in;

   // Frame buffer and its byte sequencer.
   logic [7:0] frame_ff [3];
   logic [7:0] frame_in [3];
   logic       frame_load;
   logic       busy_ff, busy_in;
   logic [2:0] pos_ff, pos_in;
   logic       esc_ff, esc_in;

   // Output register.
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic              req_fire;
   logic [TICK_W-1:0] tick_next;
   logic [TICK_W-1:0] strobe_shift;
   logic              render;
   logic [7:0]        shown [3];
   logic [7:0]        kept [3];
   logic [15:0]       product [3];
   logic              any_dec;

   logic       emit_go;
   logic [7:0] cur_byte;
   logic [2:0] cur_code;

   // A tick may render a frame, and there is only one frame buffer, so ticks wait
   // for the previous frame to leave. Note events are always taken.
   assign req_stall = busy_ff && (req_data.req_type == REQ_TICK);
   assign req_fire  = req_valid && !req_stall;

   // Tick arithmetic: the counter steps first, and the strobe follows the
   // selected bit of the new count. Exponents past the counter read as zero.
   assign tick_next    = tick_ff + TICK_W'(1);
   assign strobe_shift = tick_next >> rate_ff;
   assign render       = redraw_ff || (strobe_ff != 3'b000);

   always_comb begin
      any_dec = 1'b0;
      for (int c = 0; c < 3; c++) begin
         shown[c] = level_ff[c];
         if (render) begin
            if (strobe_ff[c]) begin
               shown[c] = strobe_shift[0] ? STROBE_HIGH : 8'd0;
            end
            if (steady_ff[c]) begin
               shown[c] = STEADY_LEVEL;
            end
         end
         // Only the low byte of the gain product reaches the link.
         product[c] = {8'd0, shown[c]} * {8'd0, gain_ff};
         // Steady channels go dark after they were shown.
         kept[c] = (render && steady_ff[c]) ? 8'd0 : shown[c];
         if (kept[c] != 8'd0) begin
            any_dec = 1'b1;
         end
      end
   end

   // State update for the accepted item.
   always_comb begin
      level_in   = level_ff;
      steady_in  = steady_ff;
      strobe_in  = strobe_ff;
      rate_in    = rate_ff;
      tick_in    = tick_ff;
      redraw_in  = redraw_ff;
      frame_in   = frame_ff;
      frame_load = 1'b0;
      if (req_fire) begin
         case (req_data.req_type)
            REQ_NOTE_ON: begin
               if (req_data.note == KEY_RATE_UP) begin
                  if (rate_ff < RATE_W'(MAX_RATE_EXP)) begin
                     rate_in = rate_ff + RATE_W'(1);
                  end
               end else if (req_data.note == KEY_RATE_DOWN) begin
                  if (rate_ff != '0) begin
                     rate_in = rate_ff - RATE_W'(1);
                  end
               end else begin
                  // The key sets are disjoint, so at most one arm matches.
                  for (int c = 0; c < 3; c++) begin
                     if (req_data.note == LEVEL_KEY[c]) begin
                        level_in[c] = {req_data.velocity, 1'b0};
                        redraw_in   = 1'b1;
                     end
                     if (req_data.note == STEADY_KEY[c]) begin
                        steady_in[c] = 1'b1;
                        redraw_in    = 1'b1;
                     end
                     if (req_data.note == STROBE_KEY[c]) begin
                        strobe_in[c] = 1'b1;
                     end
                     if (req_data.note == REDRAW_KEY[c]) begin
                        redraw_in = 1'b1;
                     end
                  end
               end
            end
            REQ_NOTE_OFF: begin
               for (int c = 0; c < 3; c++) begin
                  if (req_data.note == STEADY_KEY[c]) begin
                     steady_in[c] = 1'b0;
                     level_in[c]  = release_level_ff;
                     redraw_in    = 1'b1;
                  end
                  if (req_data.note == STROBE_KEY[c]) begin
                     strobe_in[c] = 1'b0;
                     level_in[c]  = release_level_ff;
                  end
                  if (req_data.note == REDRAW_KEY[c]) begin
                     redraw_in = 1'b1;
                  end
               end
            end
            REQ_TICK: begin
               tick_in = tick_next;
               for (int c = 0; c < 3; c++) begin
                  level_in[c] = (kept[c] != 8'd0) ? kept[c] - 8'd1 : 8'd0;
                  frame_in[c] = render ? product[c][7:0] : frame_ff[c];
               end
               // A rendered frame clears the request; any decay asks for another.
               redraw_in  = any_dec;
               frame_load = render;
            end
            default: begin
            end
         endcase
      end
   end

   // Byte sequencer: walks the frame, inserting the escape byte before any
   // reserved value. The start byte itself goes out raw.
   assign emit_go = busy_ff && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      case (pos_ff)
         POS_START: cur_byte = FRAME_START;
         POS_ZERO0: cur_byte = 8'd0;
         POS_ZERO1: cur_byte = 8'd0;
         POS_RED:   cur_byte = frame_ff[0];
         POS_GREEN: cur_byte = frame_ff[1];
         POS_BLUE:  cur_byte = frame_ff[2];
         default:   cur_byte = 8'd0;
      endcase
      cur_code = (pos_ff == POS_START) ? ESC_NONE : esc_code(cur_byte);
   end

   always_comb begin
      busy_in      = busy_ff;
      pos_in       = pos_ff;
      esc_in       = esc_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = emit_go || (rsp_valid_ff && rsp_stall);
      if (frame_load) begin
         busy_in = 1'b1;
         pos_in  = POS_START;
         esc_in  = 1'b0;
      end else if (emit_go) begin
         rsp_data_in.last = 1'b0;
         if (!esc_ff && (cur_code != ESC_NONE)) begin
            rsp_data_in.out_byte = BYTE_ESC;
            esc_in               = 1'b1;
         end else begin
            rsp_data_in.out_byte = esc_ff ? {5'd0, cur_code} : cur_byte;
            esc_in               = 1'b0;
            if (pos_ff == POS_BLUE) begin
               rsp_data_in.last = 1'b1;
               busy_in          = 1'b0;
            end else begin
               pos_in = pos_ff + 3'd1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         release_level_ff <= RELEASE_LEVEL_RESET;
         gain_ff          <= GAIN_RESET;
         level_ff         <= '{8'd0, 8'd0, 8'd0};
         steady_ff        <= 3'b000;
         strobe_ff        <= 3'b000;
         rate_ff          <= RATE_W'(RATE_EXP_RESET);
         tick_ff          <= '0;
         redraw_ff        <= 1'b1;
         busy_ff          <= 1'b0;
         pos_ff           <= POS_START;
         esc_ff           <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_we && (csr_index == CSR_RELEASE_LEVEL)) begin
            release_level_ff <= csr_wdata;
         end
         if (csr_we && (csr_index == CSR_GAIN)) begin
            gain_ff <= csr_wdata;
         end
         level_ff     <= level_in;
         steady_ff    <= steady_in;
         strobe_ff    <= strobe_in;
         rate_ff      <= rate_in;
         tick_ff      <= tick_in;
         redraw_ff    <= redraw_in;
         busy_ff      <= busy_in;
         pos_ff       <= pos_in;
         esc_ff       <= esc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      frame_ff    <= frame_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A new frame never lands on top of one that is still draining.
   `NLC_ASSERT_SAME(a_no_frame_overrun, clock, reset, frame_load, !busy_ff)
   // The escape half of a byte pair exists only inside a frame.
   `NLC_ASSERT_SAME(a_esc_in_frame, clock, reset, esc_ff, busy_ff)
   // Emitting the final byte ends the frame.
   `NLC_ASSERT_NEXT(a_last_ends_frame, clock, reset, emit_go && esc_in == 1'b0 && pos_ff == POS_BLUE && (esc_ff || cur_code == ESC_NONE), !busy_ff && rsp_valid_ff && rsp_data_ff.last)

endmodule
